/* hdl/shwh_pkg.sv */
package shwh_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned BYTES_PER_WORD = WORD_W / 8;

   // One classified message word as it waits between the front and the back.
   typedef struct packed {
      logic [WORD_W-1:0] word;       // zero-padded message bytes
      logic              has_bytes;  // word carries at least one byte
      logic              first;
      logic              last;
      logic [WORD_W-1:0] length;
   } entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEED,
      BK_MIX
   } back_state_type;

   // Keeps the low count bytes of a word; counts above four keep the whole word.
   function automatic logic [WORD_W-1:0] pad_word(input logic [WORD_W-1:0] w,
                                                  input logic [COUNT_W-1:0] count);
      logic [WORD_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         if (COUNT_W'(i) < count) begin
            mask[i*8 +: 8] = 8'hFF;
         end
      end
      return w & mask;
   endfunction

endpackage

/* hdl/shwh_front.sv */
module shwh_front (
   input  logic [shwh_pkg::WORD_W-1:0]  data_word,
   input  logic [shwh_pkg::COUNT_W-1:0] byte_count,
   input  logic                         first_item,
   input  logic                         last_item,
   input  logic [shwh_pkg::WORD_W-1:0]  message_length,
   output shwh_pkg::entry_type          entry
);

   always_comb begin
      entry.word      = shwh_pkg::pad_word(data_word, byte_count);
      entry.has_bytes = (byte_count != '0);
      entry.first     = first_item;
      entry.last      = last_item;
      entry.length    = message_length;
   end

endmodule

/* hdl/shwh_queue.sv */
module shwh_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  shwh_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output shwh_pkg::entry_type pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   shwh_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/shwh_back.sv */
module shwh_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [shwh_pkg::WORD_W-1:0] csr_data,
   input  logic                        q_not_empty,
   input  shwh_pkg::entry_type         q_data,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [shwh_pkg::WORD_W-1:0] rsp_tdata
);

   shwh_pkg::back_state_type state_ff, state_in;
   shwh_pkg::entry_type      cur_ff, cur_in;
   logic [shwh_pkg::WORD_W-1:0] seed_ff;
   logic [shwh_pkg::WORD_W-1:0] hash_ff, hash_in;
   logic                        in_msg_ff, in_msg_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [shwh_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [shwh_pkg::WORD_W-1:0] seed_prod, mix_sum, mix_prod, mixed;
   logic                        out_free, stall;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign seed_prod = seed_ff * cur_ff.length;
   assign mix_sum   = hash_ff + cur_ff.word;
   assign mix_prod  = mix_sum * seed_ff;
   assign mixed     = cur_ff.has_bytes ? mix_prod : hash_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   // A closing word waits here until the output register can take its hash.
   assign stall     = in_msg_ff && cur_ff.last && !out_free;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      hash_in      = hash_ff;
      in_msg_in    = in_msg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         shwh_pkg::BK_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               state_in = q_data.first ? shwh_pkg::BK_SEED : shwh_pkg::BK_MIX;
            end
         end
         shwh_pkg::BK_SEED: begin
            hash_in   = seed_prod;
            in_msg_in = 1'b1;
            state_in  = shwh_pkg::BK_MIX;
         end
         shwh_pkg::BK_MIX: begin
            if (!stall) begin
               if (in_msg_ff) begin
                  hash_in = mixed;
                  if (cur_ff.last) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = mixed;
                     in_msg_in    = 1'b0;
                  end
               end
               if (q_not_empty) begin
                  q_pop    = 1'b1;
                  cur_in   = q_data;
                  state_in = q_data.first ? shwh_pkg::BK_SEED : shwh_pkg::BK_MIX;
               end else begin
                  state_in = shwh_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = shwh_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shwh_pkg::BK_IDLE;
         seed_ff      <= '0;
         hash_ff      <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            seed_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hdl/seeded_word_multiply_hash_top.sv */
// A word passes the queue into the current-word register; a word that opens a message then
// passes the seed state, which loads seed times length into the hash. The mix state folds
// the word into the hash and, for a last word, into the result register. The back end pops
// the next word as it mixes one, unless a closing word waits on the output; each mix is a
// dependent add and multiply on the running hash. A 4-entry queue decouples the input.
// Reset is synchronous and active high; it clears seed, hash, queue and result valid.
module seeded_word_multiply_hash_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_word [31:0], byte_count [34:32], message_length [66:35], zeros above
   input  logic [71:0] req_tdata,
   // first_item [0]
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hash_value [31:0]
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   shwh_pkg::entry_type in_entry, q_data;
   logic q_full, q_not_empty, q_pop;

   assign req_tready = !q_full;

   shwh_front u_front (
      .data_word      (req_tdata[31:0]),
      .byte_count     (req_tdata[34:32]),
      .first_item     (req_tuser),
      .last_item      (req_tlast),
      .message_length (req_tdata[66:35]),
      .entry          (in_entry)
   );

   shwh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (in_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   shwh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* hdl/shwh_checker.sv */
module shwh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready
);

   // Closing transactions taken in minus results delivered; sticks once it saturates.
   logic [15:0] pending_ff, pending_in;
   logic        req_close, rsp_take;

   assign req_close = req_tvalid && req_tready && req_tlast;
   assign rsp_take  = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (pending_ff != 16'hFFFF) begin
         if (req_close && !rsp_take) begin
            pending_in = pending_ff + 16'd1;
         end else if (rsp_take && !req_close && pending_ff != '0) begin
            pending_in = pending_ff - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> pending_ff != '0)
      else $error("result delivered without a closing transaction");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("seed write refused");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_tready)
      else $error("input not ready after reset");

endmodule

bind seeded_word_multiply_hash_top shwh_checker u_checker (.*);
